// File: src/tlwe_pkg.sv
// Types, codes and helper functions shared by the text layout block.
// Used by tlwe_front, tlwe_walk, tlwe_back and text_layout_with_ellipsis.
package tlwe_pkg;

  localparam int SLOT_W = 22;
  localparam logic [20:0] SPACE_CP = 21'h000020;
  localparam logic [16:0] PEN_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_LOAD_RANGE = 2'd0,
    OP_LOAD_GLYPH = 2'd1,
    OP_TEXT       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_X_ORIGIN    = 3'd0,
    REG_Y_BASELINE  = 3'd1,
    REG_CLIP_WIDTH  = 3'd2,
    REG_SPACE_ADV   = 3'd3,
    REG_TEXT_COLOUR = 3'd4,
    REG_ELLIPSIS_CP = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_LOOK   = 2'd2,
    MODE_DRAIN  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EWALK,
    ST_CWALK,
    ST_RDG,
    ST_RDE,
    ST_DECIDE,
    ST_FLCHK,
    ST_FLRD,
    ST_FLEM,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  entry_index;
    logic [20:0] range_first;
    logic [8:0]  range_length;
    logic [7:0]  width_in;
    logic [7:0]  height_in;
    logic [7:0]  top_in;
    logic [15:0] offset_in;
    logic [20:0] codepoint;
    logic        last_char;
  } item_t;

  typedef struct packed {
    logic [7:0]  w;
    logic [7:0]  h;
    logic [7:0]  top;
    logic [15:0] off;
  } metric_t;

  typedef struct packed {
    logic        draw_valid;
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [7:0]  draw_w;
    logic [7:0]  draw_h;
    logic [15:0] bitmap_offset;
    logic        end_of_string;
  } res_t;

  typedef struct packed {
    logic [15:0] x_origin;
    logic [15:0] y_baseline;
    logic [15:0] clip_width;
    logic [7:0]  space_adv;
    logic [20:0] ellipsis_cp;
  } cfg_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [20:0] first;
    logic [8:0]  len;
  } range_wr_t;

  typedef struct packed {
    logic        start;
    logic [20:0] cp;
  } walk_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } walk_rsp_t;

  // Pen advance, saturating at the top of the 17-bit range.
  function automatic logic [16:0] pen_add(input logic [16:0] p, input logic [7:0] a);
    logic [17:0] s;
    s = {1'b0, p} + 18'(a);
    return s[17] ? PEN_MAX : s[16:0];
  endfunction

  // Blit command for one glyph at a pen position; x and y wrap to 16 bits.
  function automatic res_t make_res(input cfg_t c, input metric_t m, input logic [16:0] pen);
    res_t r;
    r.draw_valid    = 1'b1;
    r.draw_x        = c.x_origin + pen[15:0];
    r.draw_y        = c.y_baseline - {{8{m.top[7]}}, m.top};
    r.draw_w        = m.w;
    r.draw_h        = m.h;
    r.bitmap_offset = m.off;
    r.end_of_string = 1'b0;
    return r;
  endfunction

endpackage

// File: src/tlwe_front.sv
// Front end: two-word queue that takes input words and hands them to the back end.
// Depends on tlwe_pkg.
module tlwe_front
  import tlwe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t      entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign s_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rp];
  assign push    = s_valid && s_ready;
  assign pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= s_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: src/tlwe_walk.sv
// Code range tables and the walker that turns a codepoint into a glyph slot,
// one range entry per cycle. Depends on tlwe_pkg.
module tlwe_walk
  import tlwe_pkg::*;
#(
  parameter int MAX_RANGES = 16,
  parameter int MAX_GLYPHS = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  range_wr_t wr,
  input  walk_req_t req,
  output walk_rsp_t rsp
);

  localparam int RW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  logic [20:0]       start_tab [MAX_RANGES];
  logic [8:0]        count_tab [MAX_RANGES];
  logic              busy;
  logic [RW-1:0]     idx;
  logic [SLOT_W-1:0] base;
  logic [20:0]       cp;
  logic [20:0]       st;
  logic [8:0]        cnt;
  logic [20:0]       diff;
  logic              hit;
  logic              last_row;
  logic [SLOT_W-1:0] slot_sum;

  always_comb begin
    st       = start_tab[idx];
    cnt      = count_tab[idx];
    diff     = cp - st;
    hit      = (cp >= st) && (diff < 21'(cnt));
    last_row = (idx == RW'(MAX_RANGES - 1));
    slot_sum = base + SLOT_W'(diff);
    rsp.done  = busy && ((cnt == 9'd0) || hit || last_row);
    rsp.found = busy && (cnt != 9'd0) && hit && (slot_sum < SLOT_W'(MAX_GLYPHS));
    rsp.slot  = slot_sum;
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      start_tab[RW'(wr.idx)] <= wr.first;
      count_tab[RW'(wr.idx)] <= wr.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      idx  <= '0;
      base <= '0;
      cp   <= req.cp;
    end else if (busy) begin
      if (rsp.done) begin
        busy <= 1'b0;
      end else begin
        idx  <= idx + RW'(1);
        base <= base + SLOT_W'(cnt);
      end
    end
  end

endmodule

// File: src/tlwe_back.sv
// Back end: glyph metric memory, layout sequencer, look-ahead buffer and the
// output register. Depends on tlwe_pkg and drives the range walker.
module tlwe_back
  import tlwe_pkg::*;
#(
  parameter int MAX_RANGES      = 16,
  parameter int MAX_GLYPHS      = 256,
  parameter int LOOKAHEAD_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  item_t     q_item,
  output logic      q_pop,
  output range_wr_t range_wr,
  output walk_req_t walk_req,
  input  walk_rsp_t walk_rsp,
  output logic      m_valid,
  input  logic      m_ready,
  output res_t      m_res
);

  localparam int SW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int PW = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
  localparam int CW = $clog2(LOOKAHEAD_DEPTH + 1);

  state_t  state;
  state_t  state_next;
  mode_t   mode;
  item_t   cur;
  metric_t glyph_mem [MAX_GLYPHS];
  metric_t rdata;
  logic    rd_en;
  logic [SW-1:0] rd_addr;
  logic    mem_we;

  logic [16:0]   pen;
  logic [16:0]   lstart;
  logic [16:0]   fp;
  logic [CW-1:0] pcount;
  logic [CW-1:0] fi;
  logic [SW-1:0] pend_slot [LOOKAHEAD_DEPTH];
  logic          pend_sp   [LOOKAHEAD_DEPTH];
  logic          ell_valid;
  logic [SW-1:0] ell_slot;
  logic          found_r;
  logic [SW-1:0] slot_r;
  metric_t       gm;

  logic hold_v;
  res_t hold;
  logic ov;
  res_t ores;

  logic out_free;
  logic can_emit;
  logic fin_ok;
  logic cur_space;
  logic q_text;

  // Layout decision
  logic [7:0]  adv;
  logic        known;
  logic [16:0] newpen;
  logic [16:0] lpen;
  logic        tw;
  logic        over0;
  logic        over;
  logic        dec_emit;
  logic        dec_emit_ell;
  logic        dec_fin;
  logic        dec_flush;
  logic        dec_to_look;
  logic        dec_push_pend;
  logic        dec_pen_upd;
  logic        dec_drain;

  logic emit;
  res_t emit_res;
  logic push;
  res_t push_res;

  function automatic logic pen_gt(input logic [16:0] p, input logic [15:0] w);
    return $signed({3'b000, p}) > $signed({{4{w[15]}}, w});
  endfunction

  assign out_free  = !ov || m_ready;
  assign can_emit  = !hold_v || out_free;
  assign fin_ok    = !(hold_v || cur.last_char) || out_free;
  assign cur_space = (cur.codepoint == SPACE_CP);
  assign q_text    = q_valid && (q_item.op == OP_TEXT);

  always_comb begin
    logic signed [19:0] room;
    adv    = cur_space ? cfg.space_adv : gm.w;
    known  = cur_space || found_r;
    newpen = pen_add(pen, adv);
    room   = $signed({{4{cfg.clip_width[15]}}, cfg.clip_width})
             - $signed({3'b000, pen}) - $signed({12'h000, adv});
    tw     = ell_valid && (room < $signed({12'h000, rdata.w}));
    over0  = pen_gt(pen, cfg.clip_width);
    over   = 1'b0;
    lpen   = pen;
    dec_emit      = 1'b0;
    dec_emit_ell  = 1'b0;
    dec_fin       = 1'b0;
    dec_flush     = 1'b0;
    dec_to_look   = 1'b0;
    dec_push_pend = 1'b0;
    dec_pen_upd   = 1'b0;
    dec_drain     = 1'b0;
    if (mode == MODE_NORMAL) begin
      if (!known) begin
        dec_fin = 1'b1;
      end else if (!tw) begin
        dec_pen_upd = 1'b1;
        dec_emit    = !cur_space;
        dec_fin     = 1'b1;
      end else begin
        dec_to_look = 1'b1;
      end
    end else begin
      if (over0) begin
        over = 1'b1;
      end else if (known) begin
        dec_push_pend = 1'b1;
        dec_pen_upd   = 1'b1;
        lpen          = newpen;
        over          = (pcount == CW'(LOOKAHEAD_DEPTH - 1));
      end
      if (over) begin
        dec_emit     = 1'b1;
        dec_emit_ell = 1'b1;
        dec_drain    = 1'b1;
        dec_fin      = 1'b1;
      end else if (cur.last_char) begin
        if (pen_gt(lpen, cfg.clip_width)) begin
          dec_emit     = 1'b1;
          dec_emit_ell = 1'b1;
          dec_fin      = 1'b1;
        end else begin
          dec_flush = 1'b1;
        end
      end else begin
        dec_fin = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_text) begin
          if (mode == MODE_START) begin
            state_next = ST_EWALK;
          end else if (mode == MODE_DRAIN) begin
            state_next = ST_FIN;
          end else if (q_item.codepoint == SPACE_CP) begin
            state_next = ST_RDG;
          end else begin
            state_next = ST_CWALK;
          end
        end
      end
      ST_EWALK: begin
        if (walk_rsp.done) begin
          state_next = cur_space ? ST_RDG : ST_CWALK;
        end
      end
      ST_CWALK: begin
        if (walk_rsp.done) begin
          state_next = ST_RDG;
        end
      end
      ST_RDG: state_next = ST_RDE;
      ST_RDE: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (can_emit) begin
          if (dec_fin) begin
            state_next = ST_FIN;
          end else if (dec_flush) begin
            state_next = ST_FLCHK;
          end
        end
      end
      ST_FLCHK: begin
        if (fi == pcount) begin
          state_next = ST_FIN;
        end else if (!pend_sp[fi[PW-1:0]]) begin
          state_next = ST_FLRD;
        end
      end
      ST_FLRD: state_next = ST_FLEM;
      ST_FLEM: begin
        if (can_emit) begin
          state_next = ST_FLCHK;
        end
      end
      ST_FIN: begin
        if (fin_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop          = (state == ST_IDLE);
    range_wr.en    = (state == ST_IDLE) && q_valid && (q_item.op == OP_LOAD_RANGE)
                     && (int'(q_item.entry_index) < MAX_RANGES);
    range_wr.idx   = q_item.entry_index;
    range_wr.first = q_item.range_first;
    range_wr.len   = q_item.range_length;
    mem_we         = (state == ST_IDLE) && q_valid && (q_item.op == OP_LOAD_GLYPH)
                     && (int'(q_item.entry_index) < MAX_GLYPHS);
    walk_req.start = ((state == ST_IDLE) && q_text && (mode != MODE_DRAIN)
                      && ((mode == MODE_START) || (q_item.codepoint != SPACE_CP)))
                     || ((state == ST_EWALK) && walk_rsp.done && !cur_space);
    if (state == ST_IDLE) begin
      walk_req.cp = (mode == MODE_START) ? cfg.ellipsis_cp : q_item.codepoint;
    end else begin
      walk_req.cp = cur.codepoint;
    end
    rd_en   = (state == ST_RDG) || (state == ST_RDE) || (state == ST_FLRD);
    rd_addr = ell_slot;
    if (state == ST_RDG) begin
      rd_addr = slot_r;
    end else if (state == ST_FLRD) begin
      rd_addr = pend_slot[fi[PW-1:0]];
    end
  end

  // Emission through the hold stage into the output register
  always_comb begin
    emit     = 1'b0;
    emit_res = make_res(cfg, gm, pen);
    if (state == ST_DECIDE) begin
      emit = can_emit && dec_emit;
      if (dec_emit_ell) begin
        emit_res = make_res(cfg, rdata, lstart);
      end
    end else if (state == ST_FLEM) begin
      emit     = can_emit;
      emit_res = make_res(cfg, rdata, fp);
    end
    push     = 1'b0;
    push_res = hold;
    if ((state == ST_FIN) && fin_ok && (hold_v || cur.last_char)) begin
      push = 1'b1;
      if (hold_v) begin
        push_res.end_of_string = cur.last_char;
      end else begin
        push_res = '0;
        push_res.end_of_string = 1'b1;
      end
    end else if (emit && hold_v) begin
      push = 1'b1;
    end
  end

  assign m_valid = ov;
  assign m_res   = ores;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[SW'(q_item.entry_index)] <= metric_t'({q_item.width_in, q_item.height_in,
                                                       q_item.top_in, q_item.offset_in});
    end
    if (rd_en) begin
      rdata <= glyph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (push) begin
      ov <= 1'b1;
    end else if (m_ready) begin
      ov <= 1'b0;
    end
    if (push) begin
      ores <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_START;
      pen       <= '0;
      lstart    <= '0;
      pcount    <= '0;
      ell_valid <= 1'b0;
      ell_slot  <= '0;
      hold_v    <= 1'b0;
    end else begin
      if (emit) begin
        hold   <= emit_res;
        hold_v <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (q_text) begin
            cur <= q_item;
          end
        end
        ST_EWALK: begin
          if (walk_rsp.done) begin
            ell_valid <= walk_rsp.found;
            ell_slot  <= walk_rsp.found ? SW'(walk_rsp.slot) : '0;
            pen       <= '0;
            pcount    <= '0;
            lstart    <= '0;
            mode      <= MODE_NORMAL;
          end
        end
        ST_CWALK: begin
          if (walk_rsp.done) begin
            found_r <= walk_rsp.found;
            slot_r  <= SW'(walk_rsp.slot);
          end
        end
        ST_RDE: gm <= rdata;
        ST_DECIDE: begin
          if (can_emit) begin
            if (dec_to_look) begin
              lstart <= pen;
              pcount <= '0;
              mode   <= MODE_LOOK;
            end
            if (dec_pen_upd) begin
              pen <= newpen;
            end
            if (dec_push_pend) begin
              pend_sp[pcount[PW-1:0]]   <= cur_space;
              pend_slot[pcount[PW-1:0]] <= cur_space ? '0 : slot_r;
              pcount                    <= pcount + CW'(1);
            end
            if (dec_drain) begin
              mode <= MODE_DRAIN;
            end
            if (dec_flush) begin
              fi <= '0;
              fp <= lstart;
            end
          end
        end
        ST_FLCHK: begin
          if ((fi != pcount) && pend_sp[fi[PW-1:0]]) begin
            fp <= pen_add(fp, cfg.space_adv);
            fi <= fi + CW'(1);
          end
        end
        ST_FLEM: begin
          if (can_emit) begin
            fp <= pen_add(fp, rdata.w);
            fi <= fi + CW'(1);
          end
        end
        ST_FIN: begin
          if (fin_ok) begin
            hold_v <= 1'b0;
            if (cur.last_char) begin
              mode <= MODE_START;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Look-ahead and drain are only ever entered with an ellipsis glyph present.
  a_look_needs_ellipsis: assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_LOOK) || (mode == MODE_DRAIN)) |-> ell_valid)
    else $error("look-ahead mode without an ellipsis glyph");

  // The buffer never holds more than its depth.
  a_pcount_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= CW'(LOOKAHEAD_DEPTH))
    else $error("look-ahead count beyond depth");

  // Replay never runs past the buffered entries.
  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FLCHK) || (state == ST_FLEM)) |-> (fi <= pcount))
    else $error("replay index beyond buffered count");

  // The walker answers only while the sequencer waits for it.
  a_walk_owner: assert property (@(posedge clk) disable iff (rst)
    walk_rsp.done |-> ((state == ST_EWALK) || (state == ST_CWALK)))
    else $error("walker answer with no request outstanding");

endmodule

// File: src/text_layout_with_ellipsis.sv
// Top level of the glyph text layout block with ellipsis truncation.
// Depends on tlwe_pkg, tlwe_front, tlwe_walk and tlwe_back.
//
//   Channel   Direction  Carries
//   s_axis    in         load-range, load-glyph and text words
//   m_axis    out        blit commands and end markers
//   APB       in/out     six layout registers
//
// A load word is handled in the idle state of the sequencer as it leaves the queue.
// A text word leaves the queue, then goes through the ellipsis walk on the first
// codepoint of a string, the range walk (one range entry per cycle, skipped for a
// space), glyph read, ellipsis read, decision (made twice on entering look-ahead)
// and a finish state. At the end of a clipped string replay takes each buffered
// glyph through check, read and emit states and each buffered space through the
// check state alone.
// Reset is synchronous and active high; the font tables are undefined until
// loaded. The input queue and the output register let either side stall alone.
module text_layout_with_ellipsis
  import tlwe_pkg::*;
#(
  parameter int MAX_RANGES      = 16,
  parameter int MAX_GLYPHS      = 256,
  parameter int LOOKAHEAD_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  // Input words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[7:0], range_first[28:8], range_length[37:29], width_in[45:38],
  // height_in[53:46], top_in[61:54], offset_in[77:62], codepoint[98:78], zeros
  input  logic [103:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  // Result words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // draw_x[15:0], draw_y[31:16], draw_w[39:32], draw_h[47:40], bitmap_offset[63:48]
  output logic [63:0]  m_axis_tdata,
  // draw_valid[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t        cfg;
  logic [15:0] text_colour;
  reg_idx_t    reg_sel;
  item_t       s_item;
  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  range_wr_t   range_wr;
  walk_req_t   walk_req;
  walk_rsp_t   walk_rsp;
  res_t        m_res;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin    <= '0;
      cfg.y_baseline  <= '0;
      cfg.clip_width  <= '0;
      cfg.space_adv   <= '0;
      cfg.ellipsis_cp <= 21'd8230;
      text_colour     <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_X_ORIGIN:    cfg.x_origin    <= pwdata[15:0];
        REG_Y_BASELINE:  cfg.y_baseline  <= pwdata[15:0];
        REG_CLIP_WIDTH:  cfg.clip_width  <= pwdata[15:0];
        REG_SPACE_ADV:   cfg.space_adv   <= pwdata[7:0];
        REG_TEXT_COLOUR: text_colour     <= pwdata[15:0];
        REG_ELLIPSIS_CP: cfg.ellipsis_cp <= pwdata[20:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_X_ORIGIN:    prdata = 32'(cfg.x_origin);
      REG_Y_BASELINE:  prdata = 32'(cfg.y_baseline);
      REG_CLIP_WIDTH:  prdata = 32'(cfg.clip_width);
      REG_SPACE_ADV:   prdata = 32'(cfg.space_adv);
      REG_TEXT_COLOUR: prdata = 32'(text_colour);
      REG_ELLIPSIS_CP: prdata = 32'(cfg.ellipsis_cp);
      default:         prdata = '0;
    endcase
  end

  // Unpack the input word.
  always_comb begin
    s_item.op           = op_t'(s_axis_tuser);
    s_item.entry_index  = s_axis_tdata[7:0];
    s_item.range_first  = s_axis_tdata[28:8];
    s_item.range_length = s_axis_tdata[37:29];
    s_item.width_in     = s_axis_tdata[45:38];
    s_item.height_in    = s_axis_tdata[53:46];
    s_item.top_in       = s_axis_tdata[61:54];
    s_item.offset_in    = s_axis_tdata[77:62];
    s_item.codepoint    = s_axis_tdata[98:78];
    s_item.last_char    = s_axis_tlast;
  end

  tlwe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  tlwe_walk #(
    .MAX_RANGES (MAX_RANGES),
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_walk (
    .clk (clk),
    .rst (rst),
    .wr  (range_wr),
    .req (walk_req),
    .rsp (walk_rsp)
  );

  // Range loads beyond the table are dropped in the back end.
  tlwe_back #(
    .MAX_RANGES      (MAX_RANGES),
    .MAX_GLYPHS      (MAX_GLYPHS),
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .range_wr (range_wr),
    .walk_req (walk_req),
    .walk_rsp (walk_rsp),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_res    (m_res)
  );

  assign m_axis_tdata = {m_res.bitmap_offset, m_res.draw_h, m_res.draw_w,
                         m_res.draw_y, m_res.draw_x};
  assign m_axis_tuser = m_res.draw_valid;
  assign m_axis_tlast = m_res.end_of_string;

endmodule
